### design/tmad_pkg.sv
// ----------------------------------------------------------------------------
// tmad_pkg: shared types and constants
// Fixed field widths, conversion constants, register map, controller states
// and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package tmad_pkg;

  // field widths
  localparam int CODE_W   = 12;
  localparam int TEMP_W   = 17;
  localparam int DELTA_W  = 16;
  localparam int THRESH_W = 16;
  localparam int SLOPE_W  = 16;

  // q8 conversion: temp = offset - ((slope * code) >> 12)
  localparam logic signed [TEMP_W-1:0] OFFSET_Q8 = 17'sd37760;
  localparam logic [SLOPE_W-1:0]       SLOPE_Q8  = 16'd63360;

  // window default
  localparam int WINDOW_DEF = 8;

  // configuration port
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam int REG_IDX_W  = CFG_ADDR_W - 2;
  localparam int REG_DELTA_THRESHOLD = 0;
  localparam logic [THRESH_W-1:0] THRESH_RESET = 16'd256;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_UPD,
    ST_DLOAD,
    ST_DIV,
    ST_AVG,
    ST_FIN
  } tmad_state_t;

  typedef struct packed {
    logic cap;       // latch code, read oldest ring entry
    logic conv;      // code to q8 temperature
    logic upd;       // ring write, sum and count update
    logic dload;     // load divider from sum
    logic div_step;  // one quotient bit
    logic avg_ld;    // apply sign to quotient
    logic fin;       // baseline store or result load
  } tmad_cmd_t;

  typedef struct packed {
    logic div_done;
    logic baseline;
    logic out_busy;
  } tmad_sts_t;

endpackage

`default_nettype wire

### design/temp_moving_avg_delta_alarm_core.sv
// ----------------------------------------------------------------------------
// temp_moving_avg_delta_alarm_core: moving-average temperature alarm
// Converts sensor codes to q8 degrees, averages them over a sliding window
// and flags large changes of the average between samples.
// ----------------------------------------------------------------------------
// Each accepted word is one 12-bit adc code. It becomes a signed q8
// temperature (37760 minus 63360*code>>12), enters a ring of WINDOW samples
// and updates a running sum and fill count; the average is the sum divided by
// the fill count, truncated toward zero. The first word after reset only sets
// the baseline and gives no result word. Every later word gives one result:
// the average, the magnitude of its change from the previous average, a
// warning when that change is at or above delta_threshold (register 0, byte
// address 0, reset 256), and a flag when the warning differs from the last
// result's warning. One word at a time is processed: the next word is only
// accepted after the previous one has passed conversion, window update,
// divider load, the restoring divider by the fill count (one quotient bit
// per cycle over the SUM_W = 16 + clog2(WINDOW+1) bits of the running sum),
// the sign step and the final step. A finished result sits in an output
// register, so the next word is taken while it waits; a word only stalls at
// its final step if the previous result has still not been taken.
`default_nettype none

module temp_moving_avg_delta_alarm_core
  import tmad_pkg::*;
#(
  parameter int WINDOW = WINDOW_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // input channel
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [CODE_W-1:0]     in_adc_code,
  // result channel
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic signed [TEMP_W-1:0]   out_avg_temp,
  output logic [DELTA_W-1:0]         out_abs_delta,
  output logic                       out_warning,
  output logic                       out_state_changed,
  // configuration port
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0]      prdata,
  output logic                       pready
);

  tmad_cmd_t           cmd;
  tmad_sts_t           sts;
  logic [THRESH_W-1:0] thresh_r;
  logic                cfg_wr;
  logic                reg_hit;

  // register decode on word index, byte offset ignored
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_hit = (paddr[CFG_ADDR_W-1:2] == REG_IDX_W'(REG_DELTA_THRESHOLD));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= THRESH_RESET;
    end else if (cfg_wr && reg_hit) begin
      thresh_r <= pwdata[THRESH_W-1:0];
    end
  end

  // readback
  assign prdata = reg_hit ? CFG_DATA_W'(thresh_r) : '0;

  tmad_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  tmad_dp #(
    .WINDOW (WINDOW)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_adc_code       (in_adc_code),
    .thresh            (thresh_r),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_avg_temp      (out_avg_temp),
    .out_abs_delta     (out_abs_delta),
    .out_warning       (out_warning),
    .out_state_changed (out_state_changed),
    .sts               (sts)
  );

  // one word in flight: no back-to-back acceptance
  a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("word accepted while previous word still in progress");

  // controller issues at most one command per cycle
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("more than one datapath command at once");

  // a non-baseline finish always presents a result
  a_fin_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.fin && !sts.baseline) |=> out_valid)
    else $error("result load did not raise out_valid");

  // a result never loads over one that is still stalled
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.fin && !sts.baseline) |-> !(out_valid && out_stall))
    else $error("result overwritten while stalled");

endmodule

`default_nettype wire

### design/tmad_ctrl.sv
// ----------------------------------------------------------------------------
// tmad_ctrl: sequencing controller
// Steps each accepted word through conversion, window update, division and
// result stages.
// ----------------------------------------------------------------------------
`default_nettype none

module tmad_ctrl
  import tmad_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire tmad_sts_t sts,
  output tmad_cmd_t      cmd
);

  tmad_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_CONV;
      ST_CONV:  state_nxt = ST_UPD;
      ST_UPD:   state_nxt = ST_DLOAD;
      ST_DLOAD: state_nxt = ST_DIV;
      ST_DIV:   if (sts.div_done) state_nxt = ST_AVG;
      ST_AVG:   state_nxt = ST_FIN;
      ST_FIN:   if (sts.baseline || !sts.out_busy) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.cap  = in_valid;
      end
      ST_CONV:  cmd.conv     = 1'b1;
      ST_UPD:   cmd.upd      = 1'b1;
      ST_DLOAD: cmd.dload    = 1'b1;
      ST_DIV:   cmd.div_step = 1'b1;
      ST_AVG:   cmd.avg_ld   = 1'b1;
      ST_FIN:   cmd.fin      = sts.baseline || !sts.out_busy;
      default:  cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

### design/tmad_dp.sv
// ----------------------------------------------------------------------------
// tmad_dp: datapath
// Sample ring, running sum, restoring divider by the fill count, delta
// compare and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tmad_dp
  import tmad_pkg::*;
#(
  parameter int WINDOW = WINDOW_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire tmad_cmd_t                  cmd,
  input  wire logic [CODE_W-1:0]          in_adc_code,
  input  wire logic [THRESH_W-1:0]        thresh,
  input  wire logic                       out_stall,
  output logic                            out_valid,
  output logic signed [TEMP_W-1:0]        out_avg_temp,
  output logic [DELTA_W-1:0]              out_abs_delta,
  output logic                            out_warning,
  output logic                            out_state_changed,
  output tmad_sts_t                       sts
);

  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int POS_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SUM_W  = TEMP_W + CNT_W - 1;
  localparam int DCNT_W = $clog2(SUM_W + 1);
  localparam int PROD_W = SLOPE_W + CODE_W;

  // sample ring
  logic signed [TEMP_W-1:0] ring_mem [WINDOW];

  logic [CODE_W-1:0]        code_r;
  logic signed [TEMP_W-1:0] old_r;
  logic signed [TEMP_W-1:0] temp_r;
  logic [POS_W-1:0]         pos_r;
  logic [CNT_W-1:0]         cnt_r;
  logic signed [SUM_W-1:0]  sum_r;
  logic [CNT_W-1:0]         rem_r;
  logic [SUM_W-1:0]         quo_r;
  logic                     neg_r;
  logic [DCNT_W-1:0]        dcnt_r;
  logic signed [TEMP_W-1:0] avg_r;
  logic signed [TEMP_W-1:0] prev_avg_r;
  logic                     prev_warn_r;
  logic                     base_r;
  logic                     out_valid_r;
  logic signed [TEMP_W-1:0] avg_out_r;
  logic [DELTA_W-1:0]       delta_out_r;
  logic                     warn_out_r;
  logic                     chg_out_r;

  logic [PROD_W-1:0]        prod;
  logic signed [TEMP_W-1:0] temp_nxt;
  logic                     full;
  logic signed [SUM_W-1:0]  sum_nxt;
  logic [CNT_W-1:0]         cnt_nxt;
  logic [POS_W-1:0]         pos_nxt;
  logic [SUM_W-1:0]         sum_mag;
  logic [CNT_W:0]           trial;
  logic [CNT_W:0]           trial_sub;
  logic                     trial_ge;
  logic signed [TEMP_W-1:0] quo_s;
  logic signed [TEMP_W-1:0] avg_nxt;
  logic signed [TEMP_W:0]   delta;
  logic [TEMP_W:0]          delta_mag;
  logic [DELTA_W-1:0]       mag;
  logic                     warn;

  // q8 conversion
  assign prod     = PROD_W'(SLOPE_Q8) * PROD_W'(code_r);
  assign temp_nxt = OFFSET_Q8 - signed'({1'b0, prod[PROD_W-1:CODE_W]});

  // window update
  assign full    = (cnt_r == CNT_W'(WINDOW));
  assign sum_nxt = sum_r + signed'(SUM_W'(temp_r))
                   - (full ? signed'(SUM_W'(old_r)) : signed'(SUM_W'(0)));
  assign cnt_nxt = full ? cnt_r : cnt_r + CNT_W'(1);
  assign pos_nxt = (pos_r == POS_W'(WINDOW - 1)) ? '0 : pos_r + POS_W'(1);
  assign sum_mag = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);

  // restoring divider step
  assign trial     = {rem_r, quo_r[SUM_W-1]};
  assign trial_ge  = (trial >= {1'b0, cnt_r});
  assign trial_sub = trial - {1'b0, cnt_r};

  // sign of quotient, truncation toward zero
  assign quo_s   = signed'(quo_r[TEMP_W-1:0]);
  assign avg_nxt = neg_r ? -quo_s : quo_s;

  // delta and alarm
  assign delta     = signed'({avg_r[TEMP_W-1], avg_r})
                     - signed'({prev_avg_r[TEMP_W-1], prev_avg_r});
  assign delta_mag = delta[TEMP_W] ? (TEMP_W + 1)'(-delta) : (TEMP_W + 1)'(delta);
  assign mag       = delta_mag[DELTA_W-1:0];
  assign warn      = (mag >= thresh);

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      old_r <= ring_mem[pos_r];
    end
    if (cmd.upd) begin
      ring_mem[pos_r] <= temp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      code_r <= in_adc_code;
    end
    if (cmd.conv) begin
      temp_r <= temp_nxt;
    end
    if (cmd.dload) begin
      rem_r <= '0;
      quo_r <= sum_mag;
      neg_r <= sum_r[SUM_W-1];
    end else if (cmd.div_step) begin
      rem_r <= trial_ge ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
      quo_r <= {quo_r[SUM_W-2:0], trial_ge};
    end
    if (cmd.avg_ld) begin
      avg_r <= avg_nxt;
    end
    if (cmd.fin && !base_r) begin
      avg_out_r   <= avg_r;
      delta_out_r <= mag;
      warn_out_r  <= warn;
      chg_out_r   <= warn ^ prev_warn_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      cnt_r       <= '0;
      sum_r       <= '0;
      dcnt_r      <= '0;
      prev_avg_r  <= '0;
      prev_warn_r <= 1'b0;
      base_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.upd) begin
        pos_r <= pos_nxt;
        cnt_r <= cnt_nxt;
        sum_r <= sum_nxt;
      end
      if (cmd.dload) begin
        dcnt_r <= DCNT_W'(SUM_W);
      end else if (cmd.div_step) begin
        dcnt_r <= dcnt_r - DCNT_W'(1);
      end
      if (cmd.fin) begin
        prev_avg_r <= avg_r;
        if (base_r) begin
          base_r <= 1'b0;
        end else begin
          prev_warn_r <= warn;
        end
      end
      if (cmd.fin && !base_r) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.div_done = (dcnt_r == DCNT_W'(1));
  assign sts.baseline = base_r;
  assign sts.out_busy = out_valid_r && out_stall;

  assign out_valid         = out_valid_r;
  assign out_avg_temp      = avg_out_r;
  assign out_abs_delta     = delta_out_r;
  assign out_warning       = warn_out_r;
  assign out_state_changed = chg_out_r;

endmodule

`default_nettype wire

### tb/sv/temp_moving_avg_delta_alarm_core_tb.sv
// ----------------------------------------------------------------------------
// temp_moving_avg_delta_alarm_core_tb: self-checking bench for the alarm core
// Streams adc codes through the core under random gaps and stalls, tracks the
// moving average and the delta alarm alongside it, and checks every result
// word field by field. The threshold register is rewritten between phases.
// ----------------------------------------------------------------------------
module temp_moving_avg_delta_alarm_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tmad_pkg::*;

  localparam int WIN          = WINDOW_DEF;
  localparam int RESET_CYCLES = 11;
  localparam int MAX_REPORTS  = 10;
  // settle wait before touching config, long enough for two unstalled words
  localparam int SETTLE_CYCLES = 2 * (16 + $clog2(WIN + 1) + 6);
  // register index beyond the map, writes there must be dropped
  localparam int REG_UNUSED   = 1;

  // expected content of one result word
  typedef struct {
    logic signed [TEMP_W-1:0] avg;
    logic [DELTA_W-1:0]       delta;
    logic                     warn;
    logic                     changed;
  } alarm_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [CODE_W-1:0]         in_adc_code = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [TEMP_W-1:0]  out_avg_temp;
  logic [DELTA_W-1:0]        out_abs_delta;
  logic                      out_warning;
  logic                      out_state_changed;
  logic                      psel = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0]     paddr = '0;
  logic [CFG_DATA_W-1:0]     pwdata = '0;
  logic [CFG_DATA_W-1:0]     prdata;
  logic                      pready;

  temp_moving_avg_delta_alarm_core #(.WINDOW(WIN)) DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_adc_code       (in_adc_code),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_avg_temp      (out_avg_temp),
    .out_abs_delta     (out_abs_delta),
    .out_warning       (out_warning),
    .out_state_changed (out_state_changed),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  // 12 ns clock
  initial begin
    forever #6 clk = ~clk;
  end

  // hard stop in case the core hangs
  initial begin
    #8_000_000;
    $display("[temp_moving_avg_delta_alarm_core] ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // shadow of the core: ring, running sum, fill count, alarm history
  // --------------------------------------------------------------------------
  int              temp_ring [WIN];
  int              ring_pos = 0;
  int              ring_fill = 0;
  int              ring_sum = 0;
  int              last_avg = 0;
  bit              last_warn = 1'b0;
  bit              baseline_due = 1'b1;
  logic [THRESH_W-1:0] thresh_q8 = THRESH_RESET;

  alarm_t          alarm_q[$];      // result words still owed by the core
  logic [CODE_W-1:0] code_q[$];     // adc codes waiting to be sent
  alarm_t          oldest;

  int  mismatches = 0;
  int  gap_pct = 29;                // input side idle rate, percent
  int  stall_pct = 29;              // result side stall rate, percent
  bit  word_taken = 1'b0;           // input word accepted at the last edge
  int  walk_code = 2048;            // current point of the drifting sensor

  // one accepted code: update the window and queue the result it yields
  function automatic void track_sample(logic [CODE_W-1:0] code);
    int unsigned scaled;
    int          temp;
    int          avg;
    int          diff;
    int unsigned mag;
    bit          warn;
    alarm_t      res;
    scaled = (SLOPE_Q8 * code) >> 12;
    temp   = int'(OFFSET_Q8) - int'(scaled);
    // full window: retire the oldest sample before overwriting its slot
    if (ring_fill >= WIN) ring_sum -= temp_ring[ring_pos];
    else ring_fill++;
    temp_ring[ring_pos] = temp;
    ring_sum += temp;
    ring_pos = (ring_pos + 1) % WIN;
    avg = ring_sum / ring_fill;     // int division truncates toward zero
    // first sample after reset only seeds the previous average
    if (baseline_due) begin
      last_avg = avg;
      baseline_due = 1'b0;
      return;
    end
    diff = avg - last_avg;
    mag  = (diff < 0) ? -diff : diff;
    warn = (mag >= thresh_q8);
    res.avg     = avg[TEMP_W-1:0];
    res.delta   = mag[DELTA_W-1:0];
    res.warn    = warn;
    res.changed = (warn != last_warn);
    last_avg  = avg;
    last_warn = warn;
    alarm_q.push_back(res);
  endfunction

  // --------------------------------------------------------------------------
  // input driver: new word at the falling edge once the last one was taken
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || word_taken) begin
      if (code_q.size() != 0 && $urandom_range(99) >= gap_pct) begin
        in_valid    <= 1'b1;
        in_adc_code <= code_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < stall_pct);
  end

  // --------------------------------------------------------------------------
  // monitor: check result words, feed accepted codes to the shadow
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (alarm_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: result word with none owed: avg %0d delta %0d %s",
                     $time, out_avg_temp, out_abs_delta,
                     $sformatf("warn %0b chg %0b", out_warning, out_state_changed));
        end else begin
          oldest = alarm_q.pop_front();
          if (out_avg_temp !== oldest.avg || out_abs_delta !== oldest.delta ||
              out_warning !== oldest.warn || out_state_changed !== oldest.changed) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("%0t: result mismatch: exp %s, got %s", $time,
                       $sformatf("avg %0d delta %0d warn %0b chg %0b",
                                 oldest.avg, oldest.delta, oldest.warn,
                                 oldest.changed),
                       $sformatf("avg %0d delta %0d warn %0b chg %0b",
                                 out_avg_temp, out_abs_delta, out_warning,
                                 out_state_changed));
          end
        end
      end
      if (in_valid && !in_stall) track_sample(in_adc_code);
      word_taken <= in_valid && !in_stall;
    end else begin
      word_taken <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // configuration port access
  // --------------------------------------------------------------------------
  task automatic write_reg(input int idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'(idx << 2);
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    // only the low 16 bits of the threshold are kept, other indexes dropped
    if (idx == REG_DELTA_THRESHOLD) thresh_q8 = data[THRESH_W-1:0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_threshold_reg();
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= CFG_ADDR_W'(REG_DELTA_THRESHOLD << 2);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[THRESH_W-1:0] !== thresh_q8) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: threshold readback: exp %0d got %0d",
                 $time, thresh_q8, prdata[THRESH_W-1:0]);
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // all codes sent, all results in, then let a possible baseline word finish
  task automatic wait_settled();
    while (code_q.size() != 0 || in_valid || alarm_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // sensor drifting like a real temperature: small wander, some jumps,
  // flat stretches and now and then a fully random code
  task automatic queue_drift(input int n);
    int sel;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(99);
      if (sel < 45) walk_code += int'($urandom_range(16)) - 8;
      else if (sel < 75) walk_code += int'($urandom_range(600)) - 300;
      else if (sel >= 88) walk_code = $urandom_range(4095);
      if (walk_code < 0) walk_code = 0;
      if (walk_code > 4095) walk_code = 4095;
      code_q.push_back(CODE_W'(walk_code));
    end
  endtask

  task automatic run_phase(input logic [CFG_DATA_W-1:0] thresh_word, input int n,
                           input int idle_pct);
    wait_settled();
    write_reg(REG_DELTA_THRESHOLD, thresh_word);
    check_threshold_reg();
    gap_pct   = idle_pct;
    stall_pct = idle_pct;
    queue_drift(n);
  endtask

  // --------------------------------------------------------------------------
  // test sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // threshold must come out of reset at one degree
    check_threshold_reg();

    // directed at the reset threshold: baseline word, a flat repeat, rail to
    // rail swings, alternating bit patterns, more than a window's worth so
    // the ring wraps
    code_q = '{12'h800, 12'h800, 12'h000, 12'hFFF, 12'hFFF, 12'h000, 12'h001,
               12'hFFE, 12'hAAA, 12'h555, 12'h800, 12'h7FF, 12'h7FF};

    // zero threshold, junk in the upper bits; a write past the map is dropped
    wait_settled();
    write_reg(REG_DELTA_THRESHOLD, 32'hDEAD_0000);
    write_reg(REG_UNUSED, 32'h0000_FFFF);
    check_threshold_reg();
    // every word warns, including zero change
    code_q = '{12'h123, 12'h123, 12'h123, 12'hFFF, 12'h000, 12'h3C0, 12'h3C0,
               12'h3C0};

    // random phases over several thresholds, one with no idling at all
    run_phase(32'h5A5A_FFFF, 160, 29);     // never warns
    run_phase($urandom(), 170, 29);
    run_phase(32'hFFFF_0001, 170, 0);      // almost any change warns
    run_phase({16'($urandom()), 16'($urandom_range(600, 64))}, 170, 29);
    run_phase(32'h0000_0100, 160, 29);

    wait_settled();
    if (mismatches == 0 && alarm_q.size() == 0) begin
      $display("[temp_moving_avg_delta_alarm_core] OK");
    end else begin
      $display("[temp_moving_avg_delta_alarm_core] ERROR");
    end
    $finish;
  end

endmodule
